@@ rtl/assert_macros.svh @@
// Assertion macros shared by the badi date RTL.
// Define ASSERT_OFF to compile every check away.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef ASSERT_OFF
// Condition that must hold on every clock edge outside reset.
`define ASSERT_HOLDS(lbl, clk, rst, cond, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (cond)) else $error(msg);
// Same-cycle implication.
`define ASSERT_IMPLIES(lbl, clk, rst, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);
`else
`define ASSERT_HOLDS(lbl, clk, rst, cond, msg)
`define ASSERT_IMPLIES(lbl, clk, rst, ante, cons, msg)
`endif
`endif

@@ rtl/badi_pkg.sv @@
// Widths, constants and shared types of the badi date converter.
// No dependencies; compiled first.
package badi_pkg;

  // Field widths
  localparam int DAY_W   = 23;
  localparam int YEAR_W  = 15;
  localparam int MONTH_W = 5;
  localparam int MDAY_W  = 5;
  localparam int HOLY_W  = 3;
  localparam int VAHID_W = 10;
  localparam int YIC_W   = 5;
  localparam int KULL_W  = 6;
  localparam int DOY_W   = 9;   // day of year minus one, 0..365
  localparam int NR_W    = 25;  // signed Naw-Ruz offset from the epoch

  // First day of year 1 (1 Baha 1 BE)
  localparam logic [DAY_W-1:0] EPOCH_JDN = 23'd2394646;

  // Year length 3652422/10000, reduced to 1826211/5000
  localparam logic [12:0] YEAR_NUM    = 13'd5000;
  localparam logic [20:0] YEAR_DEN    = 21'd1826211;
  localparam int          RECIP_SHIFT = 32;
  localparam logic [23:0] RECIP_MUL   =
    24'((64'(YEAR_NUM) << RECIP_SHIFT) / 64'(YEAR_DEN));
  localparam int          PROD_W      = DAY_W + 24;
  localparam int          REM_W       = 36;

  // Naw-Ruz of year Y uses y = Y + 1843 + 4800
  localparam logic [YEAR_W-1:0] NR_YEAR_BASE = 15'd6643;
  // epoch + 32045 - 20, subtracted so that the result is days since the epoch
  localparam logic signed [NR_W-1:0] NR_BIAS = 25'sd2426671;

  // Reciprocals for constant division (floor exact over the used range)
  localparam int          DIV100_SHIFT = 22;
  localparam logic [15:0] DIV100_MUL   = 16'(((1 << DIV100_SHIFT) + 99) / 100);
  localparam int          DIV19S_SHIFT = 12;
  localparam logic [7:0]  DIV19S_MUL   = 8'(((1 << DIV19S_SHIFT) + 18) / 19);
  localparam int          DIV19_SHIFT  = 19;
  localparam logic [14:0] DIV19_MUL    = 15'(((1 << DIV19_SHIFT) + 18) / 19);
  localparam int          DIV361_SHIFT = 23;
  localparam logic [14:0] DIV361_MUL   = 15'(((1 << DIV361_SHIFT) + 360) / 361);

  // Holy-day codes
  localparam logic [HOLY_W-1:0] HOLY_NONE     = 3'd0;
  localparam logic [HOLY_W-1:0] HOLY_NAWRUZ   = 3'd1;
  localparam logic [HOLY_W-1:0] HOLY_RIDVAN1  = 3'd2;
  localparam logic [HOLY_W-1:0] HOLY_RIDVAN9  = 3'd3;
  localparam logic [HOLY_W-1:0] HOLY_RIDVAN12 = 3'd4;
  localparam logic [HOLY_W-1:0] HOLY_DECL     = 3'd5;
  localparam logic [HOLY_W-1:0] HOLY_ASCEN    = 3'd6;
  localparam logic [HOLY_W-1:0] HOLY_MARTYR   = 3'd7;

  // Year estimate handed to the Naw-Ruz stages
  typedef struct packed {
    logic              inr;
    logic [DAY_W-1:0]  d;     // days since the epoch
    logic [YEAR_W-1:0] est;   // estimated year, within one of the true one
  } badi_est_t;

  // Corrected year handed to the month split
  typedef struct packed {
    logic              inr;
    logic [YEAR_W-1:0] year;
    logic [DOY_W-1:0]  doy0;  // day of year minus one
    logic              leap;
  } badi_year_t;

  // One result word
  typedef struct packed {
    logic               in_range;
    logic [YEAR_W-1:0]  badi_year;
    logic [MONTH_W-1:0] badi_month;
    logic [MDAY_W-1:0]  badi_day;
    logic [HOLY_W-1:0]  holy_day;
    logic               leap_year;
    logic [VAHID_W-1:0] vahid;
    logic [YIC_W-1:0]   year_in_cycle;
    logic [KULL_W-1:0]  great_cycle;
  } badi_date_t;

endpackage

@@ rtl/badi_in_if.sv @@
// Input channel: one Julian day number per word.
// Depends on badi_pkg.
interface badi_in_if;
  import badi_pkg::*;

  logic             valid;
  logic             ready;
  logic [DAY_W-1:0] day_number;

  modport source (output valid, output day_number, input ready);
  modport sink   (input valid, input day_number, output ready);
endinterface

@@ rtl/badi_out_if.sv @@
// Output channel: one Badi date per word.
// Depends on badi_pkg.
interface badi_out_if;
  import badi_pkg::*;

  logic               valid;
  logic               ready;
  logic               in_range;
  logic [YEAR_W-1:0]  badi_year;
  logic [MONTH_W-1:0] badi_month;
  logic [MDAY_W-1:0]  badi_day;
  logic [HOLY_W-1:0]  holy_day;
  logic               leap_year;
  logic [VAHID_W-1:0] vahid;
  logic [YIC_W-1:0]   year_in_cycle;
  logic [KULL_W-1:0]  great_cycle;

  modport source (output valid, output in_range, output badi_year, output badi_month,
                  output badi_day, output holy_day, output leap_year, output vahid,
                  output year_in_cycle, output great_cycle, input ready);
  modport sink   (input valid, input in_range, input badi_year, input badi_month,
                  input badi_day, input holy_day, input leap_year, input vahid,
                  input year_in_cycle, input great_cycle, output ready);
endinterface

@@ rtl/badi_date_from_day_number.sv @@
// Badi date from Julian day number: nine-stage pipeline.
// Depends on badi_pkg, badi_in_if, badi_out_if, badi_year_est, badi_nawruz,
// badi_split and assert_macros.svh.
//
// Usage:
//   days  (sink)   : one Julian day number per word, valid/ready handshake.
//   dates (source) : one Badi date word per input word, in order.
//   dates.valid rises once an accepted day number has passed through all nine
//   register stages. One word is taken every cycle while dates.ready is high;
//   the nine register stages of the pipe are each about one multiply or one
//   compare deep (reciprocal year estimate, its back-multiply, the four
//   century quotients, the Naw-Ruz offsets, the month and cycle quotients).
//   Each stage moves when it is empty or the stage after it moves, so
//   bubbles are squeezed out and days.ready stays high while any stage is
//   free, even with a finished word waiting at the output.
//   When dates.ready is low the output word holds; the pipe fills behind it
//   and days.ready falls once all nine stages are full. Nothing is lost or
//   repeated.
//   Reset (rst, synchronous) clears all valid bits; the pipe is empty and
//   ready in the first cycle after reset.
//   Days before the epoch give in_range 0 and every other field 0.
module badi_date_from_day_number (
  input  logic              clk,
  input  logic              rst,
  badi_in_if.sink           days,
  badi_out_if.source        dates
);
  import badi_pkg::*;
  `include "assert_macros.svh"

  logic       est_valid, est_ready, yr_valid, yr_ready;
  badi_est_t  est;
  badi_year_t yr;
  badi_date_t date;

  // terms of the output checks
  logic word_inr, word_outr, blank_date, day_fits, ayyam_word, ayyam_fits, cycle_fits;

  badi_year_est u_est (
    .clk        (clk),
    .rst        (rst),
    .up_valid   (days.valid),
    .up_ready   (days.ready),
    .day_number (days.day_number),
    .dn_valid   (est_valid),
    .dn_ready   (est_ready),
    .est        (est)
  );

  badi_nawruz u_nawruz (
    .clk      (clk),
    .rst      (rst),
    .up_valid (est_valid),
    .up_ready (est_ready),
    .est      (est),
    .dn_valid (yr_valid),
    .dn_ready (yr_ready),
    .yr       (yr)
  );

  badi_split u_split (
    .clk      (clk),
    .rst      (rst),
    .up_valid (yr_valid),
    .up_ready (yr_ready),
    .yr       (yr),
    .dn_valid (dates.valid),
    .dn_ready (dates.ready),
    .date     (date)
  );

  // output word fields
  assign dates.in_range      = date.in_range;
  assign dates.badi_year     = date.badi_year;
  assign dates.badi_month    = date.badi_month;
  assign dates.badi_day      = date.badi_day;
  assign dates.holy_day      = date.holy_day;
  assign dates.leap_year     = date.leap_year;
  assign dates.vahid         = date.vahid;
  assign dates.year_in_cycle = date.year_in_cycle;
  assign dates.great_cycle   = date.great_cycle;

  // check terms
  assign word_inr   = dates.valid && dates.in_range;
  assign word_outr  = dates.valid && !dates.in_range;
  assign blank_date = dates.badi_year == '0 && dates.badi_month == '0 &&
                      dates.badi_day == '0 && dates.vahid == '0;
  assign day_fits   = dates.badi_day >= 5'd1 && dates.badi_day <= 5'd19 &&
                      dates.badi_month <= 5'd19;
  assign ayyam_word = word_inr && dates.badi_month == '0;
  assign ayyam_fits = dates.badi_day <= 5'(4) + 5'(dates.leap_year);
  assign cycle_fits = dates.year_in_cycle >= 5'd1 && dates.year_in_cycle <= 5'd19 &&
                      dates.vahid >= 10'd1 && dates.great_cycle >= 6'd1;

  // checks on the output word
  `ASSERT_IMPLIES(a_zero_before_epoch, clk, rst, word_outr, blank_date, "nonzero date")
  `ASSERT_IMPLIES(a_day_range, clk, rst, word_inr, day_fits, "month or day out of range")
  `ASSERT_IMPLIES(a_ayyam_len, clk, rst, ayyam_word, ayyam_fits, "Ayyam-i-Ha day too late")
  `ASSERT_IMPLIES(a_cycle_range, clk, rst, word_inr, cycle_fits, "cycle fields out of range")

endmodule

@@ rtl/badi_year_est.sv @@
// Four-stage year estimate: floor(days * 5000 / 1826211) + 1 by reciprocal
// multiply and one remainder correction. Depends on badi_pkg.
module badi_year_est (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       up_valid,
  output logic                       up_ready,
  input  logic [badi_pkg::DAY_W-1:0] day_number,
  output logic                       dn_valid,
  input  logic                       dn_ready,
  output badi_pkg::badi_est_t        est
);
  import badi_pkg::*;

  localparam int NST = 4;

  logic [NST-1:0] vld, vld_next, en;

  // stage registers
  logic              inr1, inr2, inr3;
  logic [DAY_W-1:0]  d1, d2, d3;
  logic [PROD_W-1:0] prod2;
  logic [REM_W-1:0]  d5k2, d5k3, qm3;
  logic [YEAR_W-1:0] q3;
  logic [REM_W-1:0]  rem3;
  logic              corr3;

  // stall chain: a stage moves when it is empty or the next one moves
  always_comb begin
    en[NST-1] = !vld[NST-1] || dn_ready;
    for (int i = NST - 2; i >= 0; i--) begin
      en[i] = !vld[i] || en[i+1];
    end
    vld_next[0] = en[0] ? up_valid : vld[0];
    for (int i = 1; i < NST; i++) begin
      vld_next[i] = en[i] ? vld[i-1] : vld[i];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else begin
      vld <= vld_next;
    end
  end

  assign up_ready = en[0];
  assign dn_valid = vld[NST-1];

  // remainder check: the reciprocal quotient is exact or one low
  assign rem3  = d5k3 - qm3;
  assign corr3 = rem3 >= REM_W'(YEAR_DEN);

  always_ff @(posedge clk) begin
    // stage 1: days since the epoch
    if (en[0]) begin
      inr1 <= day_number >= EPOCH_JDN;
      d1   <= (day_number >= EPOCH_JDN) ? day_number - EPOCH_JDN : '0;
    end
    // stage 2: reciprocal product and scaled dividend
    if (en[1]) begin
      inr2  <= inr1;
      d2    <= d1;
      prod2 <= PROD_W'(d1) * PROD_W'(RECIP_MUL);
      d5k2  <= REM_W'(d1) * REM_W'(YEAR_NUM);
    end
    // stage 3: back-multiply the quotient
    if (en[2]) begin
      inr3 <= inr2;
      d3   <= d2;
      d5k3 <= d5k2;
      q3   <= prod2[RECIP_SHIFT +: YEAR_W];
      qm3  <= REM_W'(prod2[RECIP_SHIFT +: YEAR_W]) * REM_W'(YEAR_DEN);
    end
    // stage 4: corrected quotient plus one
    if (en[3]) begin
      est.inr <= inr3;
      est.d   <= d3;
      est.est <= q3 + YEAR_W'(corr3) + YEAR_W'(1);
    end
  end

endmodule

@@ rtl/badi_nawruz.sv @@
// Three-stage year correction: Naw-Ruz of four neighboring years, choice of
// the year that holds the day, day of year and leap flag. Depends on badi_pkg.
module badi_nawruz (
  input  logic                clk,
  input  logic                rst,
  input  logic                up_valid,
  output logic                up_ready,
  input  badi_pkg::badi_est_t est,
  output logic                dn_valid,
  input  logic                dn_ready,
  output badi_pkg::badi_year_t yr
);
  import badi_pkg::*;

  localparam int NST   = 3;
  localparam int LANES = 4;   // years est-1 .. est+2

  logic [NST-1:0] vld, vld_next, en;

  // stage 5
  logic              inr5;
  logic [DAY_W-1:0]  d5;
  logic [YEAR_W-1:0] e5;
  logic [YEAR_W-1:0] y5   [LANES];
  logic [7:0]        c5   [LANES];   // y / 100
  // stage 6
  logic              inr6;
  logic [DAY_W-1:0]  d6;
  logic [YEAR_W-1:0] e6;
  logic signed [NR_W-1:0] nr6 [LANES];

  logic [YEAR_W-1:0] yk   [LANES];
  logic [30:0]       hk   [LANES];
  logic [NR_W-1:0]   pos  [LANES];

  logic signed [NR_W-1:0] ds, nr_sel, nr_nxt, span, off;
  logic dec, inc;

  // stall chain
  always_comb begin
    en[NST-1] = !vld[NST-1] || dn_ready;
    for (int i = NST - 2; i >= 0; i--) begin
      en[i] = !vld[i] || en[i+1];
    end
    vld_next[0] = en[0] ? up_valid : vld[0];
    for (int i = 1; i < NST; i++) begin
      vld_next[i] = en[i] ? vld[i-1] : vld[i];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else begin
      vld <= vld_next;
    end
  end

  assign up_ready = en[0];
  assign dn_valid = vld[NST-1];

  // per lane: y = year + 6643, y / 100 by reciprocal, then days since epoch
  always_comb begin
    for (int k = 0; k < LANES; k++) begin
      yk[k]  = est.est + NR_YEAR_BASE + YEAR_W'(k) - YEAR_W'(1);
      hk[k]  = 31'(yk[k]) * 31'(DIV100_MUL);
      pos[k] = NR_W'(y5[k]) * NR_W'(365) + NR_W'(y5[k] >> 2) + NR_W'(c5[k] >> 2);
    end
  end

  // pick the year whose Naw-Ruz is the last one on or before the day
  always_comb begin
    ds     = $signed(NR_W'(d6));
    dec    = (ds < nr6[1]) && (e6 > YEAR_W'(1));
    inc    = !dec && (ds >= nr6[2]);
    nr_sel = dec ? nr6[0] : (inc ? nr6[2] : nr6[1]);
    nr_nxt = dec ? nr6[1] : (inc ? nr6[3] : nr6[2]);
    span   = nr_nxt - nr_sel;
    off    = ds - nr_sel;
  end

  always_ff @(posedge clk) begin
    // stage 5: century quotient per lane
    if (en[0]) begin
      inr5 <= est.inr;
      d5   <= est.d;
      e5   <= est.est;
      for (int k = 0; k < LANES; k++) begin
        y5[k] <= yk[k];
        c5[k] <= hk[k][DIV100_SHIFT +: 8];
      end
    end
    // stage 6: Naw-Ruz offsets
    if (en[1]) begin
      inr6 <= inr5;
      d6   <= d5;
      e6   <= e5;
      for (int k = 0; k < LANES; k++) begin
        nr6[k] <= $signed(pos[k]) - $signed(NR_W'(c5[k])) - NR_BIAS;
      end
    end
    // stage 7: year, day of year, leap
    if (en[2]) begin
      yr.inr  <= inr6;
      yr.year <= e6 - YEAR_W'(dec) + YEAR_W'(inc);
      yr.doy0 <= off[DOY_W-1:0];
      yr.leap <= span == NR_W'(366);
    end
  end

endmodule

@@ rtl/badi_split.sv @@
// Two-stage split of the year and day of year into month, day, holy day,
// vahid, year in vahid and kull-i-shay. Depends on badi_pkg.
module badi_split (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 up_valid,
  output logic                 up_ready,
  input  badi_pkg::badi_year_t yr,
  output logic                 dn_valid,
  input  logic                 dn_ready,
  output badi_pkg::badi_date_t date
);
  import badi_pkg::*;

  localparam int NST = 2;

  localparam logic [DOY_W-1:0]   DAYS_18    = 9'd342;
  localparam logic [MONTH_W-1:0] MONTH_AYY  = 5'd0;
  localparam logic [MONTH_W-1:0] MONTH_LAST = 5'd19;

  function automatic logic [HOLY_W-1:0] holy_code(input logic [MONTH_W-1:0] m,
                                                  input logic [MDAY_W-1:0]  d);
    logic [HOLY_W-1:0] h;
    h = HOLY_NONE;
    if (m == 5'd1 && d == 5'd1)  h = HOLY_NAWRUZ;
    if (m == 5'd2 && d == 5'd13) h = HOLY_RIDVAN1;
    if (m == 5'd4 && d == 5'd2)  h = HOLY_RIDVAN9;
    if (m == 5'd4 && d == 5'd5)  h = HOLY_RIDVAN12;
    if (m == 5'd4 && d == 5'd8)  h = HOLY_DECL;
    if (m == 5'd4 && d == 5'd13) h = HOLY_ASCEN;
    if (m == 5'd6 && d == 5'd17) h = HOLY_MARTYR;
    return h;
  endfunction

  logic [NST-1:0] vld, vld_next, en;

  // stage 8
  logic               inr8, leap8;
  logic [DOY_W-1:0]   x8;
  logic [MONTH_W-1:0] q19_8;
  logic [YEAR_W-1:0]  yv8;
  logic [VAHID_W-1:0] vq8;
  logic [KULL_W-1:0]  gq8;

  logic [16:0]        mq;
  logic [YEAR_W-1:0]  yv;
  logic [28:0]        vp, gp;

  logic [MDAY_W-1:0]  r19, yr19;
  logic [DOY_W-1:0]   ayy;
  logic [MONTH_W-1:0] mon;
  logic [MDAY_W-1:0]  mday;

  // stall chain
  always_comb begin
    en[NST-1] = !vld[NST-1] || dn_ready;
    for (int i = NST - 2; i >= 0; i--) begin
      en[i] = !vld[i] || en[i+1];
    end
    vld_next[0] = en[0] ? up_valid : vld[0];
    for (int i = 1; i < NST; i++) begin
      vld_next[i] = en[i] ? vld[i-1] : vld[i];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else begin
      vld <= vld_next;
    end
  end

  assign up_ready = en[0];
  assign dn_valid = vld[NST-1];

  // quotients by reciprocal multiply
  assign mq = 17'(yr.doy0) * 17'(DIV19S_MUL);
  assign yv = yr.year - YEAR_W'(1);
  assign vp = 29'(yv) * 29'(DIV19_MUL);
  assign gp = 29'(yv) * 29'(DIV361_MUL);

  // remainders and the month split
  always_comb begin
    r19  = MDAY_W'(x8 - DOY_W'(q19_8) * DOY_W'(19));
    yr19 = YIC_W'(yv8 - YEAR_W'(vq8) * YEAR_W'(19));
    ayy  = leap8 ? DOY_W'(5) : DOY_W'(4);
    if (x8 < DAYS_18) begin
      mon  = q19_8 + MONTH_W'(1);
      mday = r19 + MDAY_W'(1);
    end else if (x8 < DAYS_18 + ayy) begin
      mon  = MONTH_AYY;
      mday = MDAY_W'(x8 - DAYS_18 + DOY_W'(1));
    end else begin
      mon  = MONTH_LAST;
      mday = MDAY_W'(x8 - DAYS_18 - ayy + DOY_W'(1));
    end
  end

  always_ff @(posedge clk) begin
    // stage 8: products
    if (en[0]) begin
      inr8  <= yr.inr;
      leap8 <= yr.leap;
      x8    <= yr.doy0;
      q19_8 <= mq[DIV19S_SHIFT +: MONTH_W];
      yv8   <= yv;
      vq8   <= vp[DIV19_SHIFT +: VAHID_W];
      gq8   <= gp[DIV361_SHIFT +: KULL_W];
    end
    // stage 9: output word, all zero before the epoch
    if (en[1]) begin
      date.in_range      <= inr8;
      date.badi_year     <= inr8 ? yv8 + YEAR_W'(1) : '0;
      date.badi_month    <= inr8 ? mon : '0;
      date.badi_day      <= inr8 ? mday : '0;
      date.holy_day      <= inr8 ? holy_code(mon, mday) : HOLY_NONE;
      date.leap_year     <= inr8 && leap8;
      date.vahid         <= inr8 ? vq8 + VAHID_W'(1) : '0;
      date.year_in_cycle <= inr8 ? yr19 + YIC_W'(1) : '0;
      date.great_cycle   <= inr8 ? gq8 + KULL_W'(1) : '0;
    end
  end

endmodule

@@ tb/badi_date_from_day_number_test.sv @@
// Testbench for badi_date_from_day_number: directed and random day numbers, with
// an in-bench date predictor and in-order checking of every output word.
// Depends on badi_pkg, badi_in_if, badi_out_if and the RTL top level.
`timescale 1ns / 1ps

module badi_date_from_day_number_test;
  import badi_pkg::*;

  // Year length as an exact fraction, days per year = 3652422 / 10000
  localparam longint unsigned TROPICAL_NUM   = 3652422;
  localparam longint unsigned TROPICAL_DEN   = 10000;
  localparam longint unsigned NAWRUZ_OFFSET  = 1843;
  localparam longint unsigned LEAP_OFFSET    = 1844;
  localparam longint unsigned DAYS_18_MONTHS = 18 * 19;
  localparam longint unsigned KULL_YEARS     = 361;
  localparam logic [DAY_W-1:0] DAY_MAX       = '1;
  localparam int unsigned LAST_SAFE_YEAR     = 16400;

  // Idle percentages and run sizing
  localparam int unsigned HEAVY_IDLE_PCT = 78;
  localparam int unsigned LIGHT_IDLE_PCT = 18;
  localparam int unsigned ITEMS_PER_PHASE = 490;
  localparam int unsigned DRAIN_CYCLES   = 20;
  localparam int unsigned MAX_REPORTS    = 50;

  typedef enum logic [1:0] {PH_FREE, PH_SRC_IDLE, PH_SNK_STALL, PH_BOTH} idle_phase_e;

  // Expected date together with the day it came from, for reports
  typedef struct {
    logic [DAY_W-1:0] day;
    badi_date_t       date;
  } dated_day_t;

  logic clk;
  logic rst;
  idle_phase_e idle_phase;
  int unsigned mismatches;

  logic [DAY_W-1:0] pending_days[$];
  dated_day_t       expected_dates[$];

  badi_in_if  days_if();
  badi_out_if dates_if();

  badi_date_from_day_number dut (
    .clk   (clk),
    .rst   (rst),
    .days  (days_if),
    .dates (dates_if)
  );

  // Clock, 10 ns period
  always begin
    clk = 1'b0;
    #5;
    clk = 1'b1;
    #5;
  end

  // Julian day number of March 20 of Gregorian year gy
  function automatic longint unsigned march20_day(input longint unsigned gy);
    longint unsigned y;
    y = gy + 4800;
    return 20 + 365 * y + y / 4 - y / 100 + y / 400 - 32045;
  endfunction

  function automatic longint unsigned nawruz_day(input longint unsigned yr);
    return march20_day(yr + NAWRUZ_OFFSET);
  endfunction

  function automatic bit greg_leap(input longint unsigned gy);
    return ((gy % 4 == 0) && (gy % 100 != 0)) || (gy % 400 == 0);
  endfunction

  // Expected date word for one day number
  function automatic badi_date_t predict_date(input logic [DAY_W-1:0] dn);
    longint unsigned n, yr, nr, nr_next, doy, ayyam, mon, dd;
    badi_date_t r;
    r = '0;
    n = dn;
    if (n < EPOCH_JDN) return r;
    // estimate by exact division, then one step each way
    yr = ((n - EPOCH_JDN) * TROPICAL_DEN) / TROPICAL_NUM + 1;
    nr = nawruz_day(yr);
    if (n < nr && yr > 1) begin
      yr = yr - 1;
      nr = nawruz_day(yr);
    end
    nr_next = nawruz_day(yr + 1);
    if (n >= nr_next) begin
      yr = yr + 1;
      nr = nr_next;
    end
    doy = n - nr + 1;
    ayyam = greg_leap(yr + LEAP_OFFSET) ? 5 : 4;
    // months 1-18, then Ayyam-i-Ha as month 0, then month 19
    if (doy <= DAYS_18_MONTHS) begin
      mon = (doy - 1) / 19 + 1;
      dd  = (doy - 1) % 19 + 1;
    end else if (doy <= DAYS_18_MONTHS + ayyam) begin
      mon = 0;
      dd  = doy - DAYS_18_MONTHS;
    end else begin
      mon = 19;
      dd  = doy - DAYS_18_MONTHS - ayyam;
    end
    r.in_range   = 1'b1;
    r.badi_year  = YEAR_W'(yr);
    r.badi_month = MONTH_W'(mon);
    r.badi_day   = MDAY_W'(dd);
    r.leap_year  = (ayyam == 5);
    r.vahid         = VAHID_W'((yr - 1) / 19 + 1);
    r.year_in_cycle = YIC_W'((yr - 1) % 19 + 1);
    r.great_cycle   = KULL_W'((yr - 1) / KULL_YEARS + 1);
    case ({MONTH_W'(mon), MDAY_W'(dd)})
      {5'd1, 5'd1}:  r.holy_day = HOLY_NAWRUZ;
      {5'd2, 5'd13}: r.holy_day = HOLY_RIDVAN1;
      {5'd4, 5'd2}:  r.holy_day = HOLY_RIDVAN9;
      {5'd4, 5'd5}:  r.holy_day = HOLY_RIDVAN12;
      {5'd4, 5'd8}:  r.holy_day = HOLY_DECL;
      {5'd4, 5'd13}: r.holy_day = HOLY_ASCEN;
      {5'd6, 5'd17}: r.holy_day = HOLY_MARTYR;
      default:       r.holy_day = HOLY_NONE;
    endcase
    return r;
  endfunction

  task automatic report_field(input string name, input logic [DAY_W-1:0] day,
                              input int unsigned want, input int unsigned got);
    if (want != got) begin
      if (mismatches < MAX_REPORTS)
        $display("%0t: day %0d %s mismatch, expected %0d, actual %0d",
                 $time, day, name, want, got);
      mismatches++;
    end
  endtask

  // Random day number, weighted toward year boundaries and Ayyam-i-Ha
  function automatic logic [DAY_W-1:0] random_day();
    int unsigned pick;
    longint unsigned nr;
    pick = $urandom_range(99);
    nr = nawruz_day($urandom_range(1, LAST_SAFE_YEAR));
    if (pick < 20) return DAY_W'($urandom_range(0, DAY_MAX));
    else if (pick < 28) return DAY_W'($urandom_range(0, EPOCH_JDN - 1));
    else if (pick < 55) return DAY_W'(nr + $urandom_range(0, 6) - 3);
    else if (pick < 70) return DAY_W'(nr + $urandom_range(336, 352));
    else if (pick < 85) return DAY_W'(nr + $urandom_range(0, 365));
    else return DAY_W'($urandom_range(EPOCH_JDN, DAY_MAX));
  endfunction

  // Driver: present the next pending word, with random sender gaps
  always @(posedge clk) begin : drive_days
    bit gap;
    dated_day_t entry;
    if (rst) begin
      days_if.valid      <= 1'b0;
      days_if.day_number <= '0;
    end else if (!days_if.valid || days_if.ready) begin
      if (days_if.valid) begin
        entry.day  = days_if.day_number;
        entry.date = predict_date(days_if.day_number);
        expected_dates.push_back(entry);
      end
      gap = (idle_phase == PH_SRC_IDLE && $urandom_range(99) < HEAVY_IDLE_PCT) ||
            (idle_phase == PH_BOTH && $urandom_range(99) < LIGHT_IDLE_PCT);
      if (pending_days.size() != 0 && !gap) begin
        days_if.valid      <= 1'b1;
        days_if.day_number <= pending_days.pop_front();
      end else begin
        days_if.valid <= 1'b0;
      end
    end
  end

  // Monitor: check each accepted output word, then draw the next stall
  always @(posedge clk) begin : check_dates
    bit stall;
    dated_day_t want;
    badi_date_t got;
    if (rst) begin
      dates_if.ready <= 1'b0;
    end else begin
      if (dates_if.valid && dates_if.ready) begin
        got.in_range      = dates_if.in_range;
        got.badi_year     = dates_if.badi_year;
        got.badi_month    = dates_if.badi_month;
        got.badi_day      = dates_if.badi_day;
        got.holy_day      = dates_if.holy_day;
        got.leap_year     = dates_if.leap_year;
        got.vahid         = dates_if.vahid;
        got.year_in_cycle = dates_if.year_in_cycle;
        got.great_cycle   = dates_if.great_cycle;
        if (expected_dates.size() == 0) begin
          $display("%0t: unexpected date word, expected none, actual %h", $time, got);
          mismatches++;
        end else begin
          want = expected_dates.pop_front();
          report_field("in_range", want.day, want.date.in_range, got.in_range);
          report_field("badi_year", want.day, want.date.badi_year, got.badi_year);
          report_field("badi_month", want.day, want.date.badi_month, got.badi_month);
          report_field("badi_day", want.day, want.date.badi_day, got.badi_day);
          report_field("holy_day", want.day, want.date.holy_day, got.holy_day);
          report_field("leap_year", want.day, want.date.leap_year, got.leap_year);
          report_field("vahid", want.day, want.date.vahid, got.vahid);
          report_field("year_in_cycle", want.day, want.date.year_in_cycle,
                       got.year_in_cycle);
          report_field("great_cycle", want.day, want.date.great_cycle, got.great_cycle);
        end
      end
      stall = (idle_phase == PH_SNK_STALL && $urandom_range(99) < HEAVY_IDLE_PCT) ||
              (idle_phase == PH_BOTH && $urandom_range(99) < LIGHT_IDLE_PCT);
      dates_if.ready <= !stall;
    end
  end

  // Stimulus: directed words, then one random block per idle phase
  initial begin
    longint unsigned nr;
    int unsigned holy_offsets[6];
    idle_phase = PH_FREE;
    mismatches = 0;
    days_if.valid      = 1'b0;
    days_if.day_number = '0;
    dates_if.ready     = 1'b0;
    rst = 1'b1;
    repeat (2) @(posedge clk);
    rst <= 1'b0;

    // field extremes and the epoch edge
    pending_days.push_back('0);
    pending_days.push_back(DAY_MAX);
    pending_days.push_back(DAY_MAX - 1);
    pending_days.push_back(EPOCH_JDN - 1);
    pending_days.push_back(EPOCH_JDN);
    pending_days.push_back(EPOCH_JDN + 1);
    // every holy day of year 1 after Naw-Ruz
    nr = nawruz_day(1);
    holy_offsets = '{31, 58, 61, 64, 69, 111};
    foreach (holy_offsets[i])
      pending_days.push_back(DAY_W'(nr + holy_offsets[i]));
    // four-day Ayyam-i-Ha and first day of month 19, then last day of year 1
    pending_days.push_back(DAY_W'(nr + 345));
    pending_days.push_back(DAY_W'(nr + 346));
    pending_days.push_back(DAY_W'(nawruz_day(2) - 1));
    // five-day Ayyam-i-Ha in year 4, century years 56 (no leap) and 156 (leap)
    nr = nawruz_day(4);
    pending_days.push_back(DAY_W'(nr + 342));
    pending_days.push_back(DAY_W'(nr + 346));
    pending_days.push_back(DAY_W'(nr + 347));
    pending_days.push_back(DAY_W'(nawruz_day(56) + 346));
    pending_days.push_back(DAY_W'(nawruz_day(156) + 346));
    // vahid and kull-i-shay boundaries
    pending_days.push_back(DAY_W'(nawruz_day(20)));
    pending_days.push_back(DAY_W'(nawruz_day(361) - 1));
    pending_days.push_back(DAY_W'(nawruz_day(362)));

    for (int p = 0; p < 4; p++) begin
      while (pending_days.size() != 0 || days_if.valid) @(posedge clk);
      idle_phase = idle_phase_e'(p);
      repeat (ITEMS_PER_PHASE) pending_days.push_back(random_day());
    end

    // drain: all words in, all dates back, then a quiet wait before the verdict
    while (pending_days.size() != 0 || days_if.valid) @(posedge clk);
    while (expected_dates.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (mismatches == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

  // Run limit
  initial begin
    #5ms;
    $display("FAIL");
    $finish;
  end

endmodule
